FILE: design/imu_complementary_tilt_filter_defines.svh
// Assertion macros shared by the checker.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH

// Consequent in the cycle after the antecedent, outside reset.
`define IMUCTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent in the same cycle as the antecedent, outside reset.
`define IMUCTF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checked through reset as well.
`define IMUCTF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/imuctf_pkg.sv
package imuctf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FIX_STEPS    = 5;

  localparam logic [15:0]        WEIGHT_RESET = 16'd64881;
  localparam logic signed [24:0] HALF_TURN    = 25'sd11796480;
  localparam logic [13:0]        DIV_DIVISOR  = 14'd15625;
  localparam logic [20:0]        RECIP_MULT   = 21'd1099511;
  localparam logic signed [57:0] HALF_DENOM   = 58'sd16384000000;
  localparam logic signed [57:0] DIV_BIAS     = 58'sd16384000000;
  localparam logic signed [21:0] Q_OFFSET     = 22'sd1048576;

  typedef struct packed {
    logic               done;
    logic signed [16:0] angle;
  } lane_stat_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] sat_angle(input logic signed [21:0] v);
    logic signed [16:0] r;
    if (v > 22'sd65535) begin
      r = 17'sd65535;
    end else if (v < -22'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

FILE: design/imu_complementary_tilt_filter.sv
// Complementary roll/pitch filter. Each input transaction carries one
// accelerometer triple, two gyro rates (1/64 deg/s) and the microseconds
// since the last sample; it yields one output transaction with roll and
// pitch in 1/128 degree, saturated to the 17-bit range. Two identical lanes
// run side by side, one for roll = atan2(y, z) and one for pitch =
// atan2(x, z), each with a 16-step CORDIC followed by the blend
// alpha*(prev + rate*dt) + (1-alpha)*accel, rounded to nearest. The very
// first sample after reset takes the accelerometer angles directly. One
// transaction is in flight at a time; after the accepting edge it passes
// through 16 CORDIC iterations, a rounding step for the accelerometer
// angle, three multiply/sum stages, a reciprocal-multiply quotient estimate
// and its back-multiply, five compare-and-subtract correction steps for the
// constant divide, and the load into the output register.
// The next transaction is taken the cycle after the result is written to the
// output register, even while that result is still waiting for out_ready;
// no new transaction is taken before the last one reaches that register.
// gyro_weight (alpha, unsigned Q0.16, reset 64881) is written through
// cfg_wr_en/cfg_wr_data and must only change while the block is idle.
module imu_complementary_tilt_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [17:0] in_rate_x,
  input  logic signed [17:0] in_rate_y,
  input  logic [19:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_roll_out,
  output logic signed [16:0] out_pitch_out
);
  import imuctf_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } top_st_t;

  top_st_t            st_r, st_nxt;
  logic [15:0]        weight_r;
  logic               start, load, out_free, lanes_done;
  logic               seeded;
  logic signed [16:0] roll_prev, pitch_prev;
  lane_stat_t         roll_stat, pitch_stat;

  // alpha register, to be written only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight_r <= cfg_wr_data;
    end
  end

  assign in_ready   = (st_r == T_IDLE);
  assign start      = in_valid && in_ready;
  assign lanes_done = roll_stat.done && pitch_stat.done;
  assign out_free   = !out_valid || out_ready;

  // advance when both lanes finish; hold the lane results if the output is full
  always_comb begin
    st_nxt = st_r;
    load   = 1'b0;
    case (st_r)
      T_IDLE: begin
        if (start) st_nxt = T_BUSY;
      end
      T_BUSY: begin
        if (lanes_done) begin
          if (out_free) begin
            load   = 1'b1;
            st_nxt = T_IDLE;
          end else begin
            st_nxt = T_HOLD;
          end
        end
      end
      T_HOLD: begin
        if (out_free) begin
          load   = 1'b1;
          st_nxt = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  imuctf_lane u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .num    (in_accel_y),
    .den    (in_accel_z),
    .prev   (roll_prev),
    .rate   (in_rate_x),
    .us     (in_elapsed_us),
    .weight (weight_r),
    .seeded (seeded),
    .stat   (roll_stat)
  );

  imuctf_lane u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .num    (in_accel_x),
    .den    (in_accel_z),
    .prev   (pitch_prev),
    .rate   (in_rate_y),
    .us     (in_elapsed_us),
    .weight (weight_r),
    .seeded (seeded),
    .stat   (pitch_stat)
  );

  imuctf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .roll_in    (roll_stat.angle),
    .pitch_in   (pitch_stat.angle),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .roll_out   (out_roll_out),
    .pitch_out  (out_pitch_out),
    .seeded     (seeded),
    .roll_prev  (roll_prev),
    .pitch_prev (pitch_prev)
  );

endmodule

FILE: design/imuctf_lane.sv
module imuctf_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [15:0]        num,
  input  logic signed [15:0]        den,
  input  logic signed [16:0]        prev,
  input  logic signed [17:0]        rate,
  input  logic [19:0]               us,
  input  logic [15:0]               weight,
  input  logic                      seeded,
  output imuctf_pkg::lane_stat_t    stat
);
  import imuctf_pkg::*;

  typedef enum logic [8:0] {
    L_IDLE = 9'b000000001,
    L_CORD = 9'b000000010,
    L_FIN  = 9'b000000100,
    L_MUL1 = 9'b000001000,
    L_MUL2 = 9'b000010000,
    L_SUM  = 9'b000100000,
    L_EST  = 9'b001000000,
    L_REM  = 9'b010000000,
    L_FIX  = 9'b100000000
  } lane_st_t;

  lane_st_t st_r;
  logic signed [35:0] x_r, y_r;
  logic signed [23:0] z_r;
  logic signed [24:0] base_r;
  logic               zero_r;
  logic [4:0]         cnt_r;
  logic signed [17:0] rate_r;
  logic [19:0]        us_r;
  logic signed [16:0] acc_r;
  logic signed [36:0] p5_r, a5_r;
  logic signed [38:0] ru_r;
  logic signed [56:0] t1_r;
  logic signed [54:0] t2_r;
  logic [35:0]        rem_r;
  logic [20:0]        q_r;
  logic signed [16:0] angle_r;
  logic               done_r;

  logic signed [16:0] xs, ys;
  logic signed [35:0] dx, dy;
  logic               y_pos;
  logic signed [25:0] fsum;
  logic signed [39:0] gsum;
  logic signed [17:0] wc;
  logic signed [57:0] tot;
  logic [42:0]        est_prod;
  logic [35:0]        back_prod;
  logic               fix_hit;
  logic [20:0]        q_fin;
  logic signed [21:0] qs;

  always_comb begin
    xs        = den[15] ? -17'(den) : 17'(den);
    ys        = den[15] ? -17'(num) : 17'(num);
    dx        = y_r >>> cnt_r;
    dy        = x_r >>> cnt_r;
    y_pos     = !y_r[35] && (y_r != '0);
    fsum      = 26'(base_r) + 26'(z_r) + 26'sd256;
    gsum      = 40'(p5_r) + 40'(ru_r);
    wc        = 18'sd65536 - $signed({2'b00, weight});
    tot       = 58'(t1_r) + 58'(t2_r) + HALF_DENOM;
    est_prod  = 43'(rem_r[35:14]) * 43'(RECIP_MULT);
    back_prod = 36'(q_r) * 36'(DIV_DIVISOR);
    fix_hit   = (rem_r >= 36'(DIV_DIVISOR));
    q_fin     = q_r + (fix_hit ? 21'd1 : 21'd0);
    qs        = $signed({1'b0, q_fin}) - Q_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (start) begin
            x_r    <= 36'(xs) <<< 16;
            y_r    <= 36'(ys) <<< 16;
            z_r    <= '0;
            base_r <= den[15] ? (num[15] ? -HALF_TURN : HALF_TURN) : '0;
            zero_r <= (den == '0) && (num == '0);
            cnt_r  <= '0;
            rate_r <= rate;
            us_r   <= us;
            st_r   <= L_CORD;
          end
        end
        L_CORD: begin
          if (y_pos) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + $signed({2'b00, atan_q16(cnt_r)});
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - $signed({2'b00, atan_q16(cnt_r)});
          end
          if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
            st_r <= L_FIN;
          end
          cnt_r <= cnt_r + 5'd1;
        end
        L_FIN: begin
          acc_r <= zero_r ? '0 : 17'(fsum >>> 9);
          st_r  <= L_MUL1;
        end
        L_MUL1: begin
          p5_r <= 37'(prev) * 37'sd500000;
          ru_r <= 39'(rate_r) * $signed({19'b0, us_r});
          a5_r <= 37'(acc_r) * 37'sd500000;
          st_r <= L_MUL2;
        end
        L_MUL2: begin
          t1_r <= 57'(gsum) * $signed({41'b0, weight});
          t2_r <= 55'(a5_r) * 55'(wc);
          st_r <= L_SUM;
        end
        L_SUM: begin
          rem_r <= 36'((tot >>> 21) + DIV_BIAS);
          st_r  <= L_EST;
        end
        // quotient estimate from the top bits, never above the true quotient
        L_EST: begin
          q_r  <= est_prod[40:20];
          st_r <= L_REM;
        end
        L_REM: begin
          rem_r <= rem_r - back_prod;
          cnt_r <= 5'(FIX_STEPS - 1);
          st_r  <= L_FIX;
        end
        // close the small gap left by the estimate
        L_FIX: begin
          if (fix_hit) begin
            rem_r <= rem_r - 36'(DIV_DIVISOR);
            q_r   <= q_fin;
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            st_r   <= L_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  // final angle: accelerometer only until seeded, else rounded blend
  always_ff @(posedge clk) begin
    if (st_r == L_FIX && cnt_r == '0) begin
      angle_r <= seeded ? sat_angle(qs) : acc_r;
    end
  end

  assign stat.done  = done_r;
  assign stat.angle = angle_r;

endmodule

FILE: design/imuctf_merge.sv
module imuctf_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [16:0] roll_in,
  input  logic signed [16:0] pitch_in,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [16:0] roll_out,
  output logic signed [16:0] pitch_out,
  output logic               seeded,
  output logic signed [16:0] roll_prev,
  output logic signed [16:0] pitch_prev
);
  import imuctf_pkg::*;

  logic               valid_r, seeded_r;
  logic signed [16:0] roll_r, pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      seeded_r <= 1'b0;
      roll_r   <= '0;
      pitch_r  <= '0;
    end else begin
      if (load) begin
        valid_r  <= 1'b1;
        seeded_r <= 1'b1;
        roll_r   <= roll_in;
        pitch_r  <= pitch_in;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = valid_r;
  assign roll_out   = roll_r;
  assign pitch_out  = pitch_r;
  assign seeded     = seeded_r;
  assign roll_prev  = roll_r;
  assign pitch_prev = pitch_r;

endmodule

FILE: design/imuctf_checker.sv
`include "imu_complementary_tilt_filter_defines.svh"

module imuctf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_wr_en,
  input logic [15:0]        cfg_wr_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] in_accel_x,
  input logic signed [15:0] in_accel_y,
  input logic signed [15:0] in_accel_z,
  input logic signed [17:0] in_rate_x,
  input logic signed [17:0] in_rate_y,
  input logic [19:0]        in_elapsed_us,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] out_roll_out,
  input logic signed [16:0] out_pitch_out
);

  // a new result always lands with the input side open again
  `IMUCTF_ASSERT_SAME(a_res_reopens, $rose(out_valid), in_ready, "result without ready input")

  // one transaction at a time: input closes right after an accept
  `IMUCTF_ASSERT_NEXT(a_one_flight, in_valid && in_ready, !in_ready, "second accept too soon")

  // no result comes out of reset
  `IMUCTF_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid after reset")

  // stalled result stays
  `IMUCTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_roll_out), "stalled result dropped")

endmodule

bind imu_complementary_tilt_filter imuctf_checker u_imuctf_checker (.*);

FILE: tb/sv/imu_complementary_tilt_filter_checker.sv
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [17:0] in_rate_x,
  input  logic signed [17:0] in_rate_y,
  input  logic [19:0]        in_elapsed_us,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [16:0] out_roll_out,
  input  logic signed [16:0] out_pitch_out,
  output int                 fail_count,
  output int                 pending
);
  import imuctf_pkg::*;

  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
  } tilt_t;

  localparam longint HALF_TURN_Q16 = 64'sd11796480;
  localparam longint DT_SCALE      = 64'sd500000;

  longint atan_steps [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0};

  tilt_t   tilt_queue[$];
  logic    [15:0] alpha;
  logic    primed;
  longint  roll_q, pitch_q;

  function automatic longint clamp_angle(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // Vectoring rotation toward the +x axis, angle returned in 1/128 degree.
  function automatic longint accel_angle(longint y, longint x);
    longint base, z, dx, dy;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_steps[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_steps[i];
      end
    end
    return (base + z + 256) >>> 9;
  endfunction

  function automatic longint blend_angle(longint prev, longint rate, longint us,
                                         longint acc);
    longint a, n, d, q;
    a = longint'(alpha);
    d = 64'sd65536 * DT_SCALE;
    n = a * (prev * DT_SCALE + rate * us) + (65536 - a) * acc * DT_SCALE;
    q = n + d / 2;
    // floor division
    if (q >= 0) q = q / d;
    else q = -((-q + d - 1) / d);
    return clamp_angle(q);
  endfunction

  assign pending = tilt_queue.size();

  always @(posedge clk) begin
    longint r_acc, p_acc;
    tilt_t  want;
    if (!rst_n) begin
      alpha <= WEIGHT_RESET;
      primed <= 1'b0;
      roll_q <= 0;
      pitch_q <= 0;
      fail_count <= 0;
      tilt_queue.delete();
    end else begin
      if (cfg_wr_en) alpha <= cfg_wr_data;
      if (in_valid && in_ready) begin
        r_acc = accel_angle(longint'(in_accel_y), longint'(in_accel_z));
        p_acc = accel_angle(longint'(in_accel_x), longint'(in_accel_z));
        if (!primed) begin
          r_acc = clamp_angle(r_acc);
          p_acc = clamp_angle(p_acc);
        end else begin
          r_acc = blend_angle(roll_q, longint'(in_rate_x),
                              longint'(in_elapsed_us), r_acc);
          p_acc = blend_angle(pitch_q, longint'(in_rate_y),
                              longint'(in_elapsed_us), p_acc);
        end
        primed <= 1'b1;
        roll_q <= r_acc;
        pitch_q <= p_acc;
        tilt_queue.push_back('{roll: r_acc[16:0], pitch: p_acc[16:0]});
      end
      if (out_valid && out_ready) begin
        if (tilt_queue.size() == 0) begin
          $display("%0t: unexpected result roll %0d pitch %0d", $time,
                   out_roll_out, out_pitch_out);
          fail_count <= fail_count + 1;
        end else begin
          want = tilt_queue.pop_front();
          if (want.roll !== out_roll_out || want.pitch !== out_pitch_out) begin
            $display("%0t: mismatch roll exp %0d got %0d, pitch exp %0d got %0d",
                     $time, want.roll, out_roll_out, want.pitch, out_pitch_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/imu_complementary_tilt_filter_test.sv
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_test;
  import imuctf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_accel_x;
  logic signed [15:0] in_accel_y;
  logic signed [15:0] in_accel_z;
  logic signed [17:0] in_rate_x;
  logic signed [17:0] in_rate_y;
  logic [19:0]        in_elapsed_us;
  logic               out_valid;
  logic               out_ready;
  logic signed [16:0] out_roll_out;
  logic signed [16:0] out_pitch_out;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  int                 stall_mode;

  imu_complementary_tilt_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_rate_x(in_rate_x), .in_rate_y(in_rate_y), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_out(out_roll_out), .out_pitch_out(out_pitch_out)
  );

  imu_complementary_tilt_filter_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_rate_x(in_rate_x), .in_rate_y(in_rate_y), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_out(out_roll_out), .out_pitch_out(out_pitch_out),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stall pattern: phases of always-ready, random stalls and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("imu_complementary_tilt_filter regression: fail");
        $finish;
      end
    end
  end

  // Hold the transaction until accepted; valid stays high, pause_sender drops it.
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input logic signed [17:0] rx,
                             input logic signed [17:0] ry, input logic [19:0] us);
    in_valid      <= 1'b1;
    in_accel_x    <= ax;
    in_accel_y    <= ay;
    in_accel_z    <= az;
    in_rate_x     <= rx;
    in_rate_y     <= ry;
    in_elapsed_us <= us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random sample: mostly realistic near-level tilt, sometimes full-range noise.
  task automatic send_random();
    logic signed [15:0] ax, ay, az;
    logic signed [17:0] rx, ry;
    logic [19:0]        us;
    if ($urandom_range(0, 3) != 0) begin
      ax = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      az = $signed(16'($urandom_range(0, 24000))) - 16'sd4000;
      rx = $signed(18'($urandom_range(0, 20000))) - 18'sd10000;
      ry = $signed(18'($urandom_range(0, 20000))) - 18'sd10000;
      us = 20'($urandom_range(500, 20000));
    end else begin
      ax = 16'($urandom);
      ay = 16'($urandom);
      az = 16'($urandom);
      rx = 18'($urandom);
      ry = 18'($urandom);
      us = 20'($urandom);
    end
    send_sample(ax, ay, az, rx, ry, us);
  endtask

  // Drain all outstanding results, then let the block settle before a weight change.
  task automatic drain_and_write(input logic [15:0] weight);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= weight;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && sent < count) begin
        send_random();
        sent++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 60)) pause_sender();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_accel_x    = '0;
    in_accel_y    = '0;
    in_accel_z    = '0;
    in_rate_x     = '0;
    in_rate_y     = '0;
    in_elapsed_us = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first sample is accel only, zero vector, negative z axis, extremes.
    send_sample(16'sd0, 16'sd0, 16'sd0, 18'sd131071, -18'sd131072, 20'hFFFFF);
    send_sample(16'sd0, 16'sd0, -16'sd1000, 18'sd0, 18'sd0, 20'd1000);
    send_sample(16'sd0, 16'sd0, -16'sd32768, 18'sd0, 18'sd0, 20'd1000);
    send_sample(16'sd32767, -16'sd32768, 16'sd0, 18'sd100, -18'sd100, 20'd0);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 18'sd0, 18'sd0, 20'd5000);
    send_sample(-16'sd1, 16'sd1, -16'sd1, 18'sd1, -18'sd1, 20'd1);
    // Large gyro increment drives both angles into saturation.
    send_sample(16'sd0, 16'sd0, 16'sd16384, 18'sd131071, 18'sd131071, 20'hFFFFF);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 18'sd131071, 18'sd131071, 20'hFFFFF);
    send_sample(16'sd0, 16'sd0, 16'sd16384, -18'sd131072, -18'sd131072, 20'hFFFFF);
    send_sample(16'sd0, 16'sd0, 16'sd16384, -18'sd131072, -18'sd131072, 20'hFFFFF);
    send_sample(16'sd0, 16'sd0, 16'sd16384, -18'sd131072, -18'sd131072, 20'hFFFFF);
    send_sample(16'sd1000, -16'sd1000, 16'sd16384, 18'sd0, 18'sd0, 20'd0);

    // Weight extremes, including pure accel and nearly pure gyro.
    drain_and_write(16'd0);
    send_sample(16'sd5000, -16'sd7000, 16'sd16000, 18'sd5000, -18'sd5000, 20'd10000);
    send_sample(-16'sd5000, 16'sd7000, -16'sd16000, 18'sd0, 18'sd0, 20'd10000);
    drain_and_write(16'hFFFF);
    send_sample(16'sd5000, 16'sd7000, 16'sd16000, 18'sd131071, -18'sd131072, 20'd100000);
    send_sample(16'sd0, 16'sd0, 16'sd0, -18'sd3000, 18'sd3000, 20'd300000);
    run_random(60);

    drain_and_write(16'h8000);
    run_random(80);
    drain_and_write(16'($urandom));
    run_random(80);
    drain_and_write(16'd64881);
    run_random(230);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("imu_complementary_tilt_filter regression: pass");
    end else begin
      $display("imu_complementary_tilt_filter regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/imuctf_pkg.sv
design/imuctf_lane.sv
design/imuctf_merge.sv
design/imu_complementary_tilt_filter.sv
design/imuctf_checker.sv
tb/sv/imu_complementary_tilt_filter_checker.sv
tb/sv/imu_complementary_tilt_filter_test.sv
